### design/dpc_pkg.sv
// Shared types and constants for the divisor prime/perfect checker.
`timescale 1ns / 1ps
package dpc_pkg;

  localparam int unsigned COUNT_OUT_W = 8;
  localparam int unsigned SUM_OUT_W   = 18;

  localparam int unsigned PRIME_DIVISORS = 2;
  localparam int unsigned COUNT_MAX      = 255;
  localparam int unsigned SUM_MAX        = 262143;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ADD_LO,
    ST_ADD_HI,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;       // capture value, restart trial loop
    logic div_start;  // start remainder/quotient for current trial divisor
    logic add_lo;     // account for trial divisor d
    logic add_hi;     // account for cofactor n/d, advance d
    logic out_load;   // capture result into output register
  } cmd_t;

  typedef struct packed {
    logic loop_done;  // d*d > n
    logic div_busy;
  } status_t;

endpackage

### design/dpc_if.sv
// Valid/ready channel interfaces for the checker input and result.
`timescale 1ns / 1ps
interface dpc_in_if #(
  parameter int unsigned VALUE_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface dpc_out_if;
  logic        valid;
  logic        ready;
  logic        invalid;
  logic        is_prime;
  logic        is_perfect;
  logic [7:0]  divisor_count;
  logic [17:0] proper_sum;

  modport source (output valid, output invalid, output is_prime, output is_perfect,
                  output divisor_count, output proper_sum, input ready);
  modport sink   (input valid, input invalid, input is_prime, input is_perfect,
                  input divisor_count, input proper_sum, output ready);
endinterface

### design/divisor_prime_perfect_checker_top.sv
// Top level of the trial-division prime and perfect number checker.
//
// Usage: one value enters on in_i (valid/ready, field number); one result
// transaction leaves on out_o with invalid, is_prime, is_perfect,
// divisor_count and proper_sum. A zero value gives invalid = 1 and zeros.
// The block works on one value at a time. Trial divisors d run while
// d*d <= n; each one passes the check step, the bit-serial divider and
// two accumulate steps. in_i.ready is high only while no value is in
// work. The result sits in an output register: if out_o.ready stays
// low, the next value may still be accepted and computed, then waits in
// the final state until the register is taken. After reset (rst_ni low,
// asynchronous) the block is idle with no result pending.
`timescale 1ns / 1ps
module divisor_prime_perfect_checker_top #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dpc_in_if.sink        in_i,
  dpc_out_if.source     out_o
);
  import dpc_pkg::*;

  cmd_t    cmd;
  status_t status;

  dpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dpc_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .number_i       (in_i.number),
    .invalid_o      (out_o.invalid),
    .is_prime_o     (out_o.is_prime),
    .is_perfect_o   (out_o.is_perfect),
    .divisor_count_o(out_o.divisor_count),
    .proper_sum_o   (out_o.proper_sum)
  );
endmodule

### design/dpc_divider.sv
// Restoring divider: one quotient bit per cycle, quotient and remainder.
`timescale 1ns / 1ps
module dpc_divider #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   busy_o,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [VALUE_WIDTH-1:0] remainder_o
);
  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  den_q, den_d;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;

  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = ~diff[W];
  end

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      cnt_d  = CW'(W);
      busy_d = 1'b1;
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[W-1:0] : shifted[W-1:0];
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  a_busy_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider busy with zero step count");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && cnt_q == CW'(W))
    else $error("divider did not start a full pass");
  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q == CW'(1)) |=> !busy_q)
    else $error("divider ran past its last step");
endmodule

### design/dpc_datapath.sv
// Datapath: trial divisor, square tracker, divider, accumulators, result register.
`timescale 1ns / 1ps
module dpc_datapath #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dpc_pkg::cmd_t            cmd_i,
  output dpc_pkg::status_t         status_o,
  input  logic [VALUE_WIDTH-1:0]   number_i,
  output logic                     invalid_o,
  output logic                     is_prime_o,
  output logic                     is_perfect_o,
  output logic [7:0]               divisor_count_o,
  output logic [17:0]              proper_sum_o
);
  import dpc_pkg::*;

  localparam int unsigned W      = VALUE_WIDTH;
  localparam int unsigned DW     = W / 2 + 2;
  localparam int unsigned SQW    = W + 3;
  localparam int unsigned CNT_W  = W / 2 + 2;
  localparam int unsigned SUM_W  = W + 3;
  localparam int unsigned CSAT_W = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
  localparam int unsigned SSAT_W = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;

  logic [W-1:0]      n_q;
  logic [DW-1:0]     d_q;
  logic [SQW-1:0]    sq_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SUM_W-1:0]  sum_q;

  logic [W-1:0]      quo;
  logic [W-1:0]      rem;
  logic              div_busy;
  logic              rem_zero;
  logic              d_lt_n;
  logic              q_lt_n;
  logic              q_ne_d;
  logic [CSAT_W-1:0] cnt_ext;
  logic [SSAT_W-1:0] sum_ext;

  dpc_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (n_q),
    .divisor_i  (W'(d_q)),
    .busy_o     (div_busy),
    .quotient_o (quo),
    .remainder_o(rem)
  );

  always_comb begin
    rem_zero = (rem == '0);
    d_lt_n   = (W'(d_q) < n_q);
    q_lt_n   = (quo < n_q);
    q_ne_d   = (quo != W'(d_q));
    cnt_ext  = CSAT_W'(cnt_q);
    sum_ext  = SSAT_W'(sum_q);
  end

  assign status_o.loop_done = (sq_q > SQW'(n_q));
  assign status_o.div_busy  = div_busy;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q   <= number_i;
      d_q   <= DW'(1);
      sq_q  <= SQW'(1);
      cnt_q <= '0;
      sum_q <= '0;
    end else if (cmd_i.add_lo) begin
      if (rem_zero) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (d_lt_n) begin
          sum_q <= sum_q + SUM_W'(d_q);
        end
      end
    end else if (cmd_i.add_hi) begin
      if (rem_zero && q_ne_d) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (q_lt_n) begin
          sum_q <= sum_q + SUM_W'(quo);
        end
      end
      // (d+1)^2 = d^2 + 2d + 1
      d_q  <= d_q + DW'(1);
      sq_q <= sq_q + SQW'({d_q, 1'b1});
    end
  end

  // Result register; zero input yields count 0, sum 0, so gate perfect with invalid.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      invalid_o    <= (n_q == '0);
      is_prime_o   <= (cnt_q == CNT_W'(PRIME_DIVISORS));
      is_perfect_o <= (n_q != '0) && (sum_q == SUM_W'(n_q));
      divisor_count_o <= (cnt_ext > CSAT_W'(COUNT_MAX)) ? COUNT_OUT_W'(COUNT_MAX)
                                                         : cnt_ext[COUNT_OUT_W-1:0];
      proper_sum_o    <= (sum_ext > SSAT_W'(SUM_MAX)) ? SUM_OUT_W'(SUM_MAX)
                                                       : sum_ext[SUM_OUT_W-1:0];
    end
  end

  a_load_no_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !cmd_i.div_start && !cmd_i.add_lo && !cmd_i.add_hi)
    else $error("load overlaps loop work");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy)
    else $error("divider restarted while busy");
  a_acc_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.add_lo || cmd_i.add_hi) |-> !div_busy)
    else $error("accumulate while divider busy");
endmodule

### design/dpc_ctrl.sv
// Controller: sequences load, trial-divisor loop and result handoff.
`timescale 1ns / 1ps
module dpc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dpc_pkg::status_t  status_i,
  output dpc_pkg::cmd_t     cmd_o
);
  import dpc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK:  state_d = status_i.loop_done ? ST_FINISH : ST_DIV;
      ST_DIV:    if (!status_i.div_busy) state_d = ST_ADD_LO;
      ST_ADD_LO: state_d = ST_ADD_HI;
      ST_ADD_HI: state_d = ST_CHECK;
      ST_FINISH: if (slot_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      ST_CHECK:  cmd_o.div_start = !status_i.loop_done;
      ST_DIV:    ;
      ST_ADD_LO: cmd_o.add_lo = 1'b1;
      ST_ADD_HI: cmd_o.add_hi = 1'b1;
      ST_FINISH: cmd_o.out_load = slot_free;
      default:   ;
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_CHECK)
    else $error("accepted transaction did not start the loop");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> slot_free)
    else $error("result overwrote an untaken transaction");
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && status_i.div_busy) |=> state_q == ST_DIV)
    else $error("left divide state while divider busy");
  a_lo_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ADD_LO |=> state_q == ST_ADD_HI)
    else $error("cofactor step skipped");
endmodule
